/* hw/rtl/fcou_pkg.sv */
// Shared types, constants and the arctangent table for the camera update block.
// No dependencies; imported by fcou_cordic and the top level.
package fcou_pkg;

  localparam logic [16:0] YAW_FULL = 17'd92160;
  localparam int          ATAN_N   = 24;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] CFG_MOVE_SPEED = 3'd0;
  localparam logic [2:0] CFG_LOOK_SENS  = 3'd1;
  localparam logic [2:0] CFG_UP_X       = 3'd2;
  localparam logic [2:0] CFG_UP_Y       = 3'd3;
  localparam logic [2:0] CFG_UP_Z       = 3'd4;

  typedef struct packed {
    logic               done;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cordic_res_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58665;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/fcou_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on fcou_pkg (gain, arctangent table, result struct).
module fcou_cordic import fcou_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [25:0] z_in,
  output cordic_res_t        res
);

  localparam int N  = (STEPS > ATAN_N) ? ATAN_N : STEPS;
  localparam int CW = $clog2(N);

  logic signed [33:0] x_r, y_r, shx, shy;
  logic signed [25:0] z_r, at;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r;

  assign shx = x_r >>> cnt_r;
  assign shy = y_r >>> cnt_r;
  assign at  = $signed({4'b0, atan_q16(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_GAIN;
      y_r <= '0;
      z_r <= z_in;
    end else if (busy_r) begin
      if (!z_r[25]) begin
        x_r <= x_r - shy;
        y_r <= y_r + shx;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + shy;
        y_r <= y_r - shx;
        z_r <= z_r + at;
      end
    end
  end

  assign res.done = done_r;
  assign res.c    = x_r[31:0];
  assign res.s    = y_r[31:0];

endmodule

/* hw/rtl/fcou_isqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
// No package dependencies.
module fcou_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] v_in,
  output logic        done,
  output logic [29:0] root
);

  logic [61:0] v_r, r_r, b_r, rb;
  logic        busy_r, done_r;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == 62'd1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= v_in;
      r_r <= '0;
      b_r <= 62'h1000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= rb) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[29:0];

endmodule

/* hw/rtl/fcou_div.sv */
// Restoring divider, one quotient bit per cycle, 15-bit quotient.
// Caller guarantees dividend < divisor * 2^15. No package dependencies.
module fcou_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [44:0] dividend,
  input  logic [29:0] divisor,
  output logic        done,
  output logic [14:0] quot
);

  logic [29:0] p_r, d_r;
  logic [14:0] lo_r, q_r;
  logic [30:0] pt;
  logic [3:0]  cnt_r;
  logic        busy_r, done_r, ge;

  assign pt = {p_r, lo_r[14]};
  assign ge = (pt >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'd14) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r  <= dividend[44:15];
      lo_r <= dividend[14:0];
      d_r  <= divisor;
      q_r  <= '0;
    end else if (busy_r) begin
      p_r  <= ge ? 30'(pt - {1'b0, d_r}) : pt[29:0];
      lo_r <= {lo_r[13:0], 1'b0};
      q_r  <= {q_r[13:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* hw/rtl/fps_camera_orientation_update_top.sv */
// Top level of the first-person camera update: sequencer, shared multiplier, state.
// Depends on fcou_pkg, fcou_cordic, fcou_isqrt and fcou_div.
//
// One input beat (cursor offset, four movement keys, frame time) produces one
// output beat (yaw, pitch, unit view direction, new position). Yaw turns by
// -offset_x * sensitivity and wraps to 0..360 deg; pitch turns by
// offset_y * sensitivity and is clamped to +-89 deg. The view direction comes
// from an iterative CORDIC run once for yaw and once for pitch; the strafe
// direction is the cross of view and world up, normalized through a bit-pair
// square root and a restoring divider. Position moves by speed * frame_time
// along both and saturates at POS_WIDTH bits; the output carries its low 32
// bits. Each item runs the two CORDIC passes, the 31-step square root and
// the three 15-step divides; the yaw wrap takes further steps on large turns,
// and the divides are skipped when the strafe direction is zero.
// in_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next beat is taken while it waits. Configuration
// writes are always accepted (cfg_ready tied high) and must only occur while
// the block is idle; unknown indexes are ignored.
module fps_camera_orientation_update_top import fcou_pkg::*; #(
  parameter int POS_WIDTH    = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // low to high: offset_x[12:0], offset_y[25:13], key_forward[26], key_back[27],
  // key_left[28], key_right[29], frame_time[45:30], zero pad
  input  logic [47:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // low to high: yaw_angle[16:0], pitch_angle[32:17], front_x[48:33],
  // front_y[64:49], front_z[80:65], position_x[112:81], position_y[144:113],
  // position_z[176:145], zero pad
  output logic [183:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DW    = 36;
  localparam int SUM_W = ((POS_WIDTH > DW) ? POS_WIDTH : DW) + 1;
  localparam int EXT_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;
  localparam logic signed [SUM_W-1:0] PMAX =
    {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_DX     = 20'h00002,
    ST_DY     = 20'h00004,
    ST_PITCH  = 20'h00008,
    ST_WRAP   = 20'h00010,
    ST_YAW0   = 20'h00020,
    ST_YAWC   = 20'h00040,
    ST_PITC   = 20'h00080,
    ST_FX     = 20'h00100,
    ST_FZ     = 20'h00200,
    ST_CROSS  = 20'h00400,
    ST_SQ     = 20'h00800,
    ST_SQRT_S = 20'h01000,
    ST_SQRT_W = 20'h02000,
    ST_DIV_S  = 20'h04000,
    ST_DIV_W  = 20'h08000,
    ST_SPD    = 20'h10000,
    ST_MV0    = 20'h20000,
    ST_MV     = 20'h40000,
    ST_DONE   = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] seq_r;

  // configuration
  logic [31:0]        ms_r;
  logic [15:0]        sens_r;
  logic signed [15:0] upx_r, upy_r, upz_r;

  // architectural state
  logic [16:0]                 yaw_r;
  logic signed [15:0]          pitch_r;
  logic signed [POS_WIDTH-1:0] pos_r [3];

  // captured input
  logic signed [12:0] ox_r, oy_r;
  logic               kf_r, kb_r, kl_r, kr_r;
  logic [15:0]        dt_r;

  // scratch
  logic signed [23:0] t_r;
  logic               fold_r;
  logic signed [31:0] cy_r, sy_r, cp_r, tmp_r;
  logic signed [15:0] f_r [3];
  logic signed [15:0] rv_r [3];
  logic signed [30:0] c_r [3];
  logic [61:0]        sum_r;
  logic [29:0]        norm_r;
  logic [32:0]        s_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] mul_a, mul_b;

  logic         out_valid_r;
  logic [183:0] out_data_r;

  logic in_fire, out_fire, cfg_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  function automatic logic signed [15:0] clamp_q14(input logic signed [21:0] v);
    if (v > 22'sd16384)       return 16'sd16384;
    else if (v < -22'sd16384) return -16'sd16384;
    else                      return v[15:0];
  endfunction

  // ---- turn arithmetic ----
  logic signed [30:0] dsum;
  logic signed [22:0] dval;
  logic signed [23:0] psum;
  assign dsum = $signed(prod_r[30:0]) + 31'sd128;
  assign dval = 23'(dsum >>> 8);
  assign psum = 24'(pitch_r) + 24'(dval);

  // ---- yaw angle fold ----
  logic signed [26:0] a0, a1, afold;
  logic               fold_nxt;
  always_comb begin
    a0 = $signed({2'b0, yaw_r, 8'b0});
    a1 = (a0 > 27'sd11796480) ? a0 - 27'sd23592960 : a0;
    fold_nxt = 1'b0;
    afold = a1;
    if (a1 > 27'sd5898240) begin
      afold = a1 - 27'sd11796480;
      fold_nxt = 1'b1;
    end else if (a1 < -27'sd5898240) begin
      afold = a1 + 27'sd11796480;
      fold_nxt = 1'b1;
    end
  end

  // ---- units ----
  cordic_res_t        cor;
  logic               cor_start;
  logic signed [25:0] cor_z;
  assign cor_start = (state_r == ST_YAW0) || ((state_r == ST_YAWC) && cor.done);
  assign cor_z = (state_r == ST_YAW0) ? 26'(afold) : 26'($signed({pitch_r, 8'b0}));

  fcou_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .z_in(cor_z), .res(cor)
  );

  logic        sq_done;
  logic [29:0] sq_root;
  fcou_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == ST_SQRT_S), .v_in(sum_r),
    .done(sq_done), .root(sq_root)
  );

  logic [1:0]  didx;
  logic [29:0] cmag;
  logic [44:0] dvd;
  logic        dv_done;
  logic [14:0] dv_q;
  assign didx = seq_r[1:0];
  assign cmag = c_r[didx][30] ? 30'(-c_r[didx]) : c_r[didx][29:0];
  assign dvd  = {1'b0, cmag, 14'b0} + 45'(norm_r >> 1);
  fcou_div u_div (
    .clk(clk), .rst_n(rst_n), .start((state_r == ST_DIV_S) && (norm_r != '0)),
    .dividend(dvd), .divisor(norm_r), .done(dv_done), .quot(dv_q)
  );

  // ---- shared multiplier operand select ----
  logic signed [17:0] vf, vr, vsum;
  always_comb begin
    vf = '0;
    vr = '0;
    if (kf_r && !kb_r)      vf = 18'(f_r[didx]);
    else if (kb_r && !kf_r) vf = -18'(f_r[didx]);
    if (kr_r && !kl_r)      vr = 18'(rv_r[didx]);
    else if (kl_r && !kr_r) vr = -18'(rv_r[didx]);
    vsum = vf + vr;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DX: begin
        mul_a = 34'(ox_r);
        mul_b = $signed(34'(sens_r));
      end
      ST_DY: begin
        mul_a = 34'(oy_r);
        mul_b = $signed(34'(sens_r));
      end
      ST_FX: begin
        mul_a = 34'(cy_r);
        mul_b = 34'(cp_r);
      end
      ST_FZ: begin
        mul_a = 34'(sy_r);
        mul_b = 34'(cp_r);
      end
      ST_CROSS: begin
        unique case (seq_r)
          3'd0: begin mul_a = 34'(f_r[1]); mul_b = 34'(upz_r); end
          3'd1: begin mul_a = 34'(f_r[2]); mul_b = 34'(upy_r); end
          3'd2: begin mul_a = 34'(f_r[2]); mul_b = 34'(upx_r); end
          3'd3: begin mul_a = 34'(f_r[0]); mul_b = 34'(upz_r); end
          3'd4: begin mul_a = 34'(f_r[0]); mul_b = 34'(upy_r); end
          3'd5: begin mul_a = 34'(f_r[1]); mul_b = 34'(upx_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQ: begin
        if (seq_r < 3'd3) begin
          mul_a = 34'(c_r[didx]);
          mul_b = 34'(c_r[didx]);
        end
      end
      ST_SPD: begin
        mul_a = $signed(34'(ms_r));
        mul_b = $signed(34'(dt_r));
      end
      ST_MV: begin
        if (seq_r < 3'd3) begin
          mul_a = $signed(34'(s_r));
          mul_b = 34'(vsum);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---- consumers of the previous product ----
  logic [1:0]         pidx;
  logic signed [21:0] q14_raw;
  logic signed [31:0] p32;
  logic signed [DW-1:0]    delta;
  logic signed [SUM_W-1:0] pnew;
  logic signed [32:0]      fy_sum;
  assign pidx    = 2'(seq_r - 3'd1);
  assign q14_raw = 22'((prod_r + (68'sd1 <<< 45)) >>> 46);
  assign p32     = $signed(prod_r[31:0]);
  assign delta   = $signed(prod_r[49:14]);
  assign pnew    = SUM_W'(pos_r[pidx]) + SUM_W'(delta);
  assign fy_sum  = 33'(cor.s) + 33'sd32768;

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_DX;
      ST_DX:     state_nxt = ST_DY;
      ST_DY:     state_nxt = ST_PITCH;
      ST_PITCH:  state_nxt = ST_WRAP;
      ST_WRAP: begin
        if (!t_r[23] && (t_r < 24'sd92160)) state_nxt = ST_YAW0;
      end
      ST_YAW0:   state_nxt = ST_YAWC;
      ST_YAWC:   if (cor.done) state_nxt = ST_PITC;
      ST_PITC:   if (cor.done) state_nxt = ST_FX;
      ST_FX:     state_nxt = ST_FZ;
      ST_FZ:     state_nxt = ST_CROSS;
      ST_CROSS:  if (seq_r == 3'd6) state_nxt = ST_SQ;
      ST_SQ:     if (seq_r == 3'd3) state_nxt = ST_SQRT_S;
      ST_SQRT_S: state_nxt = ST_SQRT_W;
      ST_SQRT_W: if (sq_done) state_nxt = ST_DIV_S;
      ST_DIV_S:  state_nxt = (norm_r == '0) ? ST_SPD : ST_DIV_W;
      ST_DIV_W: begin
        if (dv_done) state_nxt = (seq_r == 3'd2) ? ST_SPD : ST_DIV_S;
      end
      ST_SPD:    state_nxt = ST_MV0;
      ST_MV0:    state_nxt = ST_MV;
      ST_MV:     if (seq_r == 3'd3) state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
      ms_r        <= '0;
      sens_r      <= 16'd6554;
      upx_r       <= '0;
      upy_r       <= 16'sd16384;
      upz_r       <= '0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          CFG_MOVE_SPEED: ms_r   <= cfg_data;
          CFG_LOOK_SENS:  sens_r <= cfg_data[15:0];
          CFG_UP_X:       upx_r  <= $signed(cfg_data[15:0]);
          CFG_UP_Y:       upy_r  <= $signed(cfg_data[15:0]);
          CFG_UP_Z:       upz_r  <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (state_r == ST_PITCH) begin
        if (psum > 24'sd22784)       pitch_r <= 16'sd22784;
        else if (psum < -24'sd22784) pitch_r <= -16'sd22784;
        else                         pitch_r <= psum[15:0];
      end
      if ((state_r == ST_WRAP) && (state_nxt == ST_YAW0)) yaw_r <= t_r[16:0];
      if ((state_r == ST_MV) && (seq_r != 3'd0)) begin
        if (pnew > PMAX)      pos_r[pidx] <= PMAX[POS_WIDTH-1:0];
        else if (pnew < PMIN) pos_r[pidx] <= PMIN[POS_WIDTH-1:0];
        else                  pos_r[pidx] <= pnew[POS_WIDTH-1:0];
      end
      // step counter shared by the multi-beat states; the divide loop keeps
      // its component index across the start/wait pair
      priority if (state_nxt != state_r) begin
        if (state_r == ST_DIV_W && state_nxt == ST_DIV_S) seq_r <= seq_r + 1'b1;
        else if (state_r != ST_DIV_S)                     seq_r <= '0;
      end else if (state_r == ST_CROSS || state_r == ST_SQ || state_r == ST_MV) begin
        seq_r <= seq_r + 1'b1;
      end
      if (state_r == ST_DONE && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
      else if (out_fire)                              out_valid_r <= 1'b0;
    end
  end

  // datapath scratch registers
  logic signed [EXT_W-1:0] px_e, py_e, pz_e;
  assign px_e = EXT_W'(pos_r[0]);
  assign py_e = EXT_W'(pos_r[1]);
  assign pz_e = EXT_W'(pos_r[2]);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ox_r <= $signed(in_tdata[12:0]);
      oy_r <= $signed(in_tdata[25:13]);
      kf_r <= in_tdata[26];
      kb_r <= in_tdata[27];
      kl_r <= in_tdata[28];
      kr_r <= in_tdata[29];
      dt_r <= in_tdata[45:30];
    end
    unique case (state_r)
      ST_DY: t_r <= $signed({7'b0, yaw_r}) - 24'(dval);
      ST_WRAP: begin
        if (t_r[23])                  t_r <= t_r + 24'sd92160;
        else if (t_r >= 24'sd92160)   t_r <= t_r - 24'sd92160;
      end
      ST_YAW0: fold_r <= fold_nxt;
      ST_YAWC: begin
        if (cor.done) begin
          cy_r <= fold_r ? -cor.c : cor.c;
          sy_r <= fold_r ? -cor.s : cor.s;
        end
      end
      ST_PITC: begin
        if (cor.done) begin
          cp_r   <= cor.c;
          f_r[1] <= clamp_q14(22'(fy_sum >>> 16));
        end
      end
      ST_FZ: f_r[0] <= clamp_q14(q14_raw);
      ST_CROSS: begin
        if (seq_r == 3'd0)   f_r[2] <= clamp_q14(q14_raw);
        else if (!pidx[0] && (seq_r != 3'd5)) tmp_r <= p32;
        else if (seq_r == 3'd5) tmp_r <= p32;
        if (seq_r == 3'd2) c_r[0] <= 31'(tmp_r - p32);
        if (seq_r == 3'd4) c_r[1] <= 31'(tmp_r - p32);
        if (seq_r == 3'd6) c_r[2] <= 31'(tmp_r - p32);
      end
      ST_SQ: begin
        if (seq_r == 3'd0) sum_r <= '0;
        else               sum_r <= sum_r + prod_r[61:0];
      end
      ST_SQRT_W: if (sq_done) norm_r <= sq_root;
      ST_DIV_S: begin
        if (norm_r == '0) begin
          for (int i = 0; i < 3; i++) rv_r[i] <= '0;
        end
      end
      ST_DIV_W: begin
        if (dv_done) rv_r[didx] <= c_r[didx][30] ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
      end
      ST_MV0: s_r <= prod_r[48:16];
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {7'b0, pz_e[31:0], py_e[31:0], px_e[31:0],
                         f_r[2], f_r[1], f_r[0], pitch_r, yaw_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- checks ----
  ast_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    yaw_r < YAW_FULL) else $error("yaw out of range");

  ast_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= 16'sd22784) && (pitch_r >= -16'sd22784)) else $error("pitch out of range");

  ast_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE)) else $error("result without sequence end");

  ast_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cor.done && !sq_done && !dv_done)
    else $error("unit finished while sequencer idle");

endmodule
